@@ hdl/rsrf_pkg.sv @@
// ----------------------------------------------------------------------------
// rsrf_pkg: shared types and constants for the ray segment range finder
// Command and register codes, sequencer states, widths and the sine table.
// ----------------------------------------------------------------------------
package rsrf_pkg;

   localparam int MAX_OBST = 64;
   localparam int WALL_AW  = $clog2(MAX_OBST);
   localparam int CNT_W    = $clog2(MAX_OBST + 1);

   // coordinate, multiplier operand, product, wide accumulate and quotient widths
   localparam int CW = 28;
   localparam int MW = 33;
   localparam int PW = 2 * MW;
   localparam int WW = 64;
   localparam int QW = 36;

   localparam logic [15:0] FULL_TURN    = 16'd36000;
   localparam logic [15:0] QUARTER_TURN = 16'd9000;
   localparam logic [4:0]  TAB_LAST     = 5'd18;
   localparam logic [13:0] STEP_500     = 14'd500;
   // floor(x/500) = (x * RCP_IDX) >> 22 for x <= 9000
   localparam logic [13:0] RCP_IDX      = 14'd8389;
   // floor(y/500) = (y * RCP_FRAC) >> 28 for y < 2^20
   localparam logic [19:0] RCP_FRAC     = 20'd536871;
   localparam logic [19:0] NO_HIT_Q8    = 20'd512000;

   localparam int DIV_T_STEPS = 32;
   localparam int DIV_R_STEPS = QW;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      REG_HALF_LENGTH  = 1'b0,
      REG_SENSOR_RANGE = 1'b1
   } reg_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SETUP,
      ST_SQ_MUL_IDX,
      ST_SQ_SPLIT,
      ST_SQ_MUL_DIFF,
      ST_SQ_MUL_RCP,
      ST_SQ_FIN,
      ST_QUAD,
      ST_RAY0,
      ST_RAY1,
      ST_RAY2,
      ST_RAY3,
      ST_RAY4,
      ST_RAY5,
      ST_WNEXT,
      ST_WPREP,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5,
      ST_M6,
      ST_M7,
      ST_SIGN,
      ST_TEST,
      ST_NORM,
      ST_DIV,
      ST_STEP,
      ST_EXQ,
      ST_EXCHK,
      ST_CMP,
      ST_WINC,
      ST_FIN,
      ST_DONE
   } state_type;

   // sin at every 5 degrees, Q1.14
   function automatic logic [14:0] sin5_lookup(input logic [4:0] idx);
      logic [14:0] v;
      case (idx)
         5'd0:    v = 15'd0;
         5'd1:    v = 15'd1428;
         5'd2:    v = 15'd2845;
         5'd3:    v = 15'd4240;
         5'd4:    v = 15'd5604;
         5'd5:    v = 15'd6924;
         5'd6:    v = 15'd8192;
         5'd7:    v = 15'd9397;
         5'd8:    v = 15'd10531;
         5'd9:    v = 15'd11585;
         5'd10:   v = 15'd12551;
         5'd11:   v = 15'd13421;
         5'd12:   v = 15'd14189;
         5'd13:   v = 15'd14849;
         5'd14:   v = 15'd15396;
         5'd15:   v = 15'd15826;
         5'd16:   v = 15'd16135;
         5'd17:   v = 15'd16322;
         default: v = 15'd16384;
      endcase
      return v;
   endfunction

endpackage

@@ hdl/ray_segment_range_finder.sv @@
// ----------------------------------------------------------------------------
// ray_segment_range_finder: forward range sensor against stored wall segments
// Keeps up to MAX_OBST walls and casts a ray from the pose along the heading.
//
//   channel  dir  ports                     content
//   req      in   req_tvalid/tready/tdata   walls, pose, heading; tuser = cmd
//   rsp      out  rsp_tvalid/tready/tdata   distance, hit, status, wall_count
//   csr      in   csr_we/addr/wdata         half_length, sensor_range
//
// Clear, append and unused commands skip the query steps. A query runs a setup
// and a finish, and for each stored wall an intersection test and, on a hit,
// normalize shifts and 32 + 36 divider steps: all of it runs through one shared
// 33x33 multiplier and one radix-2 divider.
// Reset is synchronous; walls read back only after being appended.
// The result sits in an output register; a stalled rsp holds the block in done.
// ----------------------------------------------------------------------------
module ray_segment_range_finder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // wall_ax, wall_ay, wall_bx, wall_by, pose_x, pose_y, heading
   input  logic [127:0] req_tdata,
   // cmd
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance, hit, status, wall_count, zero pad
   output logic [23:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [0:0]   csr_addr,
   input  logic [11:0]  csr_wdata
);

   localparam int CW = rsrf_pkg::CW;
   localparam int MW = rsrf_pkg::MW;
   localparam int PW = rsrf_pkg::PW;
   localparam int WW = rsrf_pkg::WW;
   localparam int QW = rsrf_pkg::QW;
   localparam int CNT_W = rsrf_pkg::CNT_W;
   localparam int WALL_AW = rsrf_pkg::WALL_AW;

   rsrf_pkg::state_type state_ff, state_in;

   logic [9:0]  hl_ff;
   logic [11:0] sr_ff;
   logic [CNT_W-1:0] wall_total_ff, wi_ff;
   logic [63:0] wall_mem [rsrf_pkg::MAX_OBST];
   logic [63:0] rd_ff;
   logic        full;

   rsrf_pkg::cmd_type cmd_ff;
   logic [63:0] wall_ff;
   logic signed [23:0] px_ff, py_ff;
   logic [15:0] heading_ff;

   logic [13:0] r_ff, arg_ff;
   logic [1:0]  quad_ff;
   logic        trig_sel_ff;
   logic [14:0] base_ff, s_ff, c_ff;
   logic [10:0] diff_ff;
   logic [8:0]  f_ff;
   logic signed [15:0] sn_ff, cs_ff;

   logic signed [CW-1:0] rsx_ff, rsy_ff, rex_ff, rey_ff, rx_ff, ry_ff, offx_ff;
   logic signed [CW-1:0] wdx_ff, wdy_ff, ex_ff, ey_ff, exq_ff;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_ff;
   logic signed [WW-1:0] pa_ff, d_ff, nt_ff, nu_ff;

   logic [30:0]   rem_ff, dvs_ff;
   logic [QW-1:0] num_ff, q_ff;
   logic [5:0]    cnt_ff;
   logic          div_kind_ff;  // 0: ray parameter, 1: range

   logic [19:0] best_ff;
   logic        any_ff;
   logic [10:0] res_dist_ff;
   logic        res_hit_ff, res_status_ff;
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;

   // ---------------------------------------------------------------- helpers
   logic [15:0] hmod;
   logic [12:0] span;
   logic [4:0]  idx_sat;
   logic [14:0] tab_lo, tab_hi;
   logic signed [CW-1:0] rsx_a, rsy_a, rx_abs, step, exq_abs;
   logic signed [15:0] ax, ay, bx, by;
   logic signed [16:0] x1, y1;
   logic signed [CW-1:0] wx1, wy1;
   logic [31:0] div_tmp;
   logic        div_ge;
   logic signed [15:0] cs_abs;
   logic [QW-1:0] hlq, comp;
   logic        test_ok;

   assign full = (wall_total_ff == CNT_W'(rsrf_pkg::MAX_OBST));
   assign span = 13'(hl_ff) + 13'(sr_ff);
   assign hmod = (heading_ff >= rsrf_pkg::FULL_TURN) ? heading_ff - rsrf_pkg::FULL_TURN
                                                     : heading_ff;

   always_comb begin
      idx_sat = (prod_ff[26:22] > rsrf_pkg::TAB_LAST) ? rsrf_pkg::TAB_LAST : prod_ff[26:22];
      tab_lo  = rsrf_pkg::sin5_lookup(idx_sat);
      tab_hi  = (idx_sat == rsrf_pkg::TAB_LAST) ? tab_lo
                                                : rsrf_pkg::sin5_lookup(idx_sat + 5'd1);
   end

   // degenerate ray: nudge the start by one unit
   assign rsx_a = (rsx_ff == rex_ff) ? rsx_ff + CW'(256) : rsx_ff;
   assign rsy_a = (rsy_ff == rey_ff) ? rsy_ff + CW'(256) : rsy_ff;
   assign rx_abs = rx_ff[CW-1] ? -rx_ff : rx_ff;

   assign ax = $signed(rd_ff[15:0]);
   assign ay = $signed(rd_ff[31:16]);
   assign bx = $signed(rd_ff[47:32]);
   assign by = $signed(rd_ff[63:48]);
   assign x1 = 17'(ax) + ((ax == bx) ? 17'sd1 : 17'sd0);
   assign y1 = 17'(ay) + ((ay == by) ? 17'sd1 : 17'sd0);
   assign wx1 = CW'(x1) <<< 8;
   assign wy1 = CW'(y1) <<< 8;

   assign test_ok = !nt_ff[WW-1] && (nt_ff != '0) && (nt_ff < d_ff) &&
                    !nu_ff[WW-1] && (nu_ff != '0) && (nu_ff < d_ff);

   assign div_tmp = {1'b0, rem_ff} << 1 | 32'(num_ff[QW-1]);
   assign div_ge  = (div_tmp >= {1'b0, dvs_ff});

   // a ray parameter of exactly one steps the full ray length
   assign step    = q_ff[32] ? rx_abs : CW'(prod_ff[58:32]);
   assign exq_abs = exq_ff[CW-1] ? -exq_ff : exq_ff;
   assign cs_abs  = cs_ff[15] ? -cs_ff : cs_ff;
   assign hlq     = QW'({hl_ff, 8'b0});
   assign comp    = (q_ff < hlq) ? '0 : q_ff - hlq;

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsrf_pkg::ST_IDLE:        if (req_tvalid) state_in = rsrf_pkg::ST_EXEC;
         rsrf_pkg::ST_EXEC:        state_in = (cmd_ff == rsrf_pkg::CMD_QUERY) ?
                                              rsrf_pkg::ST_SETUP : rsrf_pkg::ST_DONE;
         rsrf_pkg::ST_SETUP:       state_in = rsrf_pkg::ST_SQ_MUL_IDX;
         rsrf_pkg::ST_SQ_MUL_IDX:  state_in = rsrf_pkg::ST_SQ_SPLIT;
         rsrf_pkg::ST_SQ_SPLIT:    state_in = rsrf_pkg::ST_SQ_MUL_DIFF;
         rsrf_pkg::ST_SQ_MUL_DIFF: state_in = rsrf_pkg::ST_SQ_MUL_RCP;
         rsrf_pkg::ST_SQ_MUL_RCP:  state_in = rsrf_pkg::ST_SQ_FIN;
         rsrf_pkg::ST_SQ_FIN:      state_in = trig_sel_ff ? rsrf_pkg::ST_QUAD
                                                          : rsrf_pkg::ST_SQ_MUL_IDX;
         rsrf_pkg::ST_QUAD:        state_in = rsrf_pkg::ST_RAY0;
         rsrf_pkg::ST_RAY0:        state_in = rsrf_pkg::ST_RAY1;
         rsrf_pkg::ST_RAY1:        state_in = rsrf_pkg::ST_RAY2;
         rsrf_pkg::ST_RAY2:        state_in = rsrf_pkg::ST_RAY3;
         rsrf_pkg::ST_RAY3:        state_in = rsrf_pkg::ST_RAY4;
         rsrf_pkg::ST_RAY4:        state_in = rsrf_pkg::ST_RAY5;
         rsrf_pkg::ST_RAY5:        state_in = rsrf_pkg::ST_WNEXT;
         rsrf_pkg::ST_WNEXT:       state_in = (wi_ff == wall_total_ff) ?
                                              rsrf_pkg::ST_FIN : rsrf_pkg::ST_WPREP;
         rsrf_pkg::ST_WPREP:       state_in = rsrf_pkg::ST_M1;
         rsrf_pkg::ST_M1:          state_in = rsrf_pkg::ST_M2;
         rsrf_pkg::ST_M2:          state_in = rsrf_pkg::ST_M3;
         rsrf_pkg::ST_M3:          state_in = rsrf_pkg::ST_M4;
         rsrf_pkg::ST_M4:          state_in = rsrf_pkg::ST_M5;
         rsrf_pkg::ST_M5:          state_in = rsrf_pkg::ST_M6;
         rsrf_pkg::ST_M6:          state_in = rsrf_pkg::ST_M7;
         rsrf_pkg::ST_M7:          state_in = rsrf_pkg::ST_SIGN;
         rsrf_pkg::ST_SIGN:        state_in = (d_ff == '0) ? rsrf_pkg::ST_WINC
                                                           : rsrf_pkg::ST_TEST;
         rsrf_pkg::ST_TEST:        state_in = test_ok ? rsrf_pkg::ST_NORM : rsrf_pkg::ST_WINC;
         rsrf_pkg::ST_NORM:        if (d_ff[WW-1:31] == '0) state_in = rsrf_pkg::ST_DIV;
         rsrf_pkg::ST_DIV:         if (cnt_ff == 6'd1) begin
            state_in = div_kind_ff ? rsrf_pkg::ST_CMP : rsrf_pkg::ST_STEP;
         end
         rsrf_pkg::ST_STEP:        state_in = rsrf_pkg::ST_EXQ;
         rsrf_pkg::ST_EXQ:         state_in = rsrf_pkg::ST_EXCHK;
         rsrf_pkg::ST_EXCHK:       state_in = (exq_ff == '0 || cs_ff == '0) ?
                                              rsrf_pkg::ST_WINC : rsrf_pkg::ST_DIV;
         rsrf_pkg::ST_CMP:         state_in = rsrf_pkg::ST_WINC;
         rsrf_pkg::ST_WINC:        state_in = rsrf_pkg::ST_WNEXT;
         rsrf_pkg::ST_FIN:         state_in = rsrf_pkg::ST_DONE;
         rsrf_pkg::ST_DONE:        if (!rsp_valid_ff || rsp_tready) state_in = rsrf_pkg::ST_IDLE;
         default:                  state_in = rsrf_pkg::ST_IDLE;
      endcase
   end

   // --------------------------------------------- outputs: handshake, multiplier
   always_comb begin
      req_tready = (state_ff == rsrf_pkg::ST_IDLE);
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         rsrf_pkg::ST_SQ_MUL_IDX:  begin mul_a = MW'(arg_ff);        mul_b = MW'(rsrf_pkg::RCP_IDX);  end
         rsrf_pkg::ST_SQ_MUL_DIFF: begin mul_a = MW'(diff_ff);       mul_b = MW'(f_ff);               end
         rsrf_pkg::ST_SQ_MUL_RCP:  begin mul_a = MW'(prod_ff[19:0]); mul_b = MW'(rsrf_pkg::RCP_FRAC); end
         rsrf_pkg::ST_RAY0:        begin mul_a = MW'(cs_ff);         mul_b = MW'(hl_ff);              end
         rsrf_pkg::ST_RAY1:        begin mul_a = MW'(sn_ff);         mul_b = MW'(hl_ff);              end
         rsrf_pkg::ST_RAY2:        begin mul_a = MW'(cs_ff);         mul_b = MW'(span);               end
         rsrf_pkg::ST_RAY3:        begin mul_a = MW'(sn_ff);         mul_b = MW'(span);               end
         rsrf_pkg::ST_M1:          begin mul_a = MW'(rx_ff);         mul_b = MW'(wdy_ff);             end
         rsrf_pkg::ST_M2:          begin mul_a = MW'(ry_ff);         mul_b = MW'(wdx_ff);             end
         rsrf_pkg::ST_M3:          begin mul_a = MW'(ex_ff);         mul_b = MW'(wdy_ff);             end
         rsrf_pkg::ST_M4:          begin mul_a = MW'(ey_ff);         mul_b = MW'(wdx_ff);             end
         rsrf_pkg::ST_M5:          begin mul_a = MW'(ex_ff);         mul_b = MW'(ry_ff);              end
         rsrf_pkg::ST_M6:          begin mul_a = MW'(ey_ff);         mul_b = MW'(rx_ff);              end
         rsrf_pkg::ST_STEP:        begin mul_a = MW'(q_ff[31:0]);    mul_b = MW'(rx_abs);             end
         default:                  begin mul_a = '0;                 mul_b = '0;                      end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rsrf_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         wall_total_ff <= '0;
         hl_ff         <= 10'd50;
         sr_ff         <= 12'd1200;
      end else begin
         state_ff <= state_in;
         if (state_ff == rsrf_pkg::ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == rsrf_pkg::ST_EXEC) begin
            if (cmd_ff == rsrf_pkg::CMD_CLEAR) begin
               wall_total_ff <= '0;
            end else if (cmd_ff == rsrf_pkg::CMD_APPEND && !full) begin
               wall_total_ff <= wall_total_ff + CNT_W'(1);
            end
         end
         if (csr_we) begin
            unique case (rsrf_pkg::reg_type'(csr_addr))
               rsrf_pkg::REG_HALF_LENGTH:  hl_ff <= csr_wdata[9:0];
               rsrf_pkg::REG_SENSOR_RANGE: sr_ff <= csr_wdata;
            endcase
         end
      end
   end

   // ----------------------------------------------------------- wall memory
   always_ff @(posedge clock) begin
      if (state_ff == rsrf_pkg::ST_EXEC && cmd_ff == rsrf_pkg::CMD_APPEND && !full) begin
         wall_mem[wall_total_ff[WALL_AW-1:0]] <= wall_ff;
      end
      rd_ff <= wall_mem[wi_ff[WALL_AW-1:0]];
   end

   // --------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         rsrf_pkg::ST_IDLE: begin
            cmd_ff     <= rsrf_pkg::cmd_type'(req_tuser);
            wall_ff    <= req_tdata[63:0];
            px_ff      <= $signed(req_tdata[87:64]);
            py_ff      <= $signed(req_tdata[111:88]);
            heading_ff <= req_tdata[127:112];
         end
         rsrf_pkg::ST_EXEC: begin
            res_dist_ff   <= '0;
            res_hit_ff    <= 1'b0;
            res_status_ff <= (cmd_ff == rsrf_pkg::CMD_APPEND) && full;
         end
         rsrf_pkg::ST_SETUP: begin
            trig_sel_ff <= 1'b0;
            if (hmod < rsrf_pkg::QUARTER_TURN) begin
               quad_ff <= 2'd0;
               r_ff    <= 14'(hmod);
               arg_ff  <= 14'(hmod);
            end else if (hmod < 2 * rsrf_pkg::QUARTER_TURN) begin
               quad_ff <= 2'd1;
               r_ff    <= 14'(hmod - rsrf_pkg::QUARTER_TURN);
               arg_ff  <= 14'(hmod - rsrf_pkg::QUARTER_TURN);
            end else if (hmod < 3 * rsrf_pkg::QUARTER_TURN) begin
               quad_ff <= 2'd2;
               r_ff    <= 14'(hmod - 2 * rsrf_pkg::QUARTER_TURN);
               arg_ff  <= 14'(hmod - 2 * rsrf_pkg::QUARTER_TURN);
            end else begin
               quad_ff <= 2'd3;
               r_ff    <= 14'(hmod - 3 * rsrf_pkg::QUARTER_TURN);
               arg_ff  <= 14'(hmod - 3 * rsrf_pkg::QUARTER_TURN);
            end
         end
         rsrf_pkg::ST_SQ_SPLIT: begin
            base_ff <= tab_lo;
            diff_ff <= 11'(tab_hi - tab_lo);
            f_ff    <= 9'(arg_ff - 14'(idx_sat) * rsrf_pkg::STEP_500);
         end
         rsrf_pkg::ST_SQ_FIN: begin
            if (!trig_sel_ff) begin
               s_ff        <= base_ff + 15'(prod_ff[38:28]);
               arg_ff      <= 14'(rsrf_pkg::QUARTER_TURN) - r_ff;
               trig_sel_ff <= 1'b1;
            end else begin
               c_ff <= base_ff + 15'(prod_ff[38:28]);
            end
         end
         rsrf_pkg::ST_QUAD: begin
            case (quad_ff)
               2'd0:    begin sn_ff <= 16'(s_ff);  cs_ff <= 16'(c_ff);  end
               2'd1:    begin sn_ff <= 16'(c_ff);  cs_ff <= -16'(s_ff); end
               2'd2:    begin sn_ff <= -16'(s_ff); cs_ff <= -16'(c_ff); end
               default: begin sn_ff <= -16'(c_ff); cs_ff <= 16'(s_ff);  end
            endcase
         end
         // products arrive in the state after their operands; >>> 6 is floor(/64)
         rsrf_pkg::ST_RAY1: rsx_ff <= CW'(px_ff) + CW'($signed(prod_ff[33:6]));
         rsrf_pkg::ST_RAY2: rsy_ff <= CW'(py_ff) + CW'($signed(prod_ff[33:6]));
         rsrf_pkg::ST_RAY3: rex_ff <= CW'(px_ff) + CW'($signed(prod_ff[33:6]));
         rsrf_pkg::ST_RAY4: rey_ff <= CW'(py_ff) + CW'($signed(prod_ff[33:6]));
         rsrf_pkg::ST_RAY5: begin
            rsx_ff  <= rsx_a;
            rsy_ff  <= rsy_a;
            rx_ff   <= rex_ff - rsx_a;
            ry_ff   <= rey_ff - rsy_a;
            offx_ff <= rsx_a - CW'(px_ff);
            wi_ff   <= '0;
            best_ff <= rsrf_pkg::NO_HIT_Q8;
            any_ff  <= 1'b0;
         end
         rsrf_pkg::ST_WPREP: begin
            wdx_ff <= (CW'(bx) - CW'(x1)) <<< 8;
            wdy_ff <= (CW'(by) - CW'(y1)) <<< 8;
            ex_ff  <= wx1 - rsx_ff;
            ey_ff  <= wy1 - rsy_ff;
         end
         rsrf_pkg::ST_M2: pa_ff <= WW'(prod_ff);
         rsrf_pkg::ST_M3: d_ff  <= pa_ff - WW'(prod_ff);
         rsrf_pkg::ST_M4: pa_ff <= WW'(prod_ff);
         rsrf_pkg::ST_M5: nt_ff <= pa_ff - WW'(prod_ff);
         rsrf_pkg::ST_M6: pa_ff <= WW'(prod_ff);
         rsrf_pkg::ST_M7: nu_ff <= pa_ff - WW'(prod_ff);
         rsrf_pkg::ST_SIGN: begin
            if (d_ff[WW-1]) begin
               d_ff  <= -d_ff;
               nt_ff <= -nt_ff;
               nu_ff <= -nu_ff;
            end
         end
         rsrf_pkg::ST_NORM: begin
            if (d_ff[WW-1:31] != '0) begin
               d_ff  <= d_ff >>> 1;
               nt_ff <= nt_ff >>> 1;
            end else begin
               // t = (nt << 32) / d; nt < d so the first 32 steps are already done
               if (nt_ff[30:0] == d_ff[30:0]) begin
                  // halving made them equal: quotient is exactly 2^32
                  rem_ff <= '0;
                  q_ff   <= QW'(1);
               end else begin
                  rem_ff <= nt_ff[30:0];
                  q_ff   <= '0;
               end
               dvs_ff      <= d_ff[30:0];
               num_ff      <= '0;
               cnt_ff      <= 6'(rsrf_pkg::DIV_T_STEPS);
               div_kind_ff <= 1'b0;
            end
         end
         rsrf_pkg::ST_DIV: begin
            rem_ff <= div_ge ? 31'(div_tmp - {1'b0, dvs_ff}) : div_tmp[30:0];
            q_ff   <= {q_ff[QW-2:0], div_ge};
            num_ff <= num_ff << 1;
            cnt_ff <= cnt_ff - 6'd1;
         end
         rsrf_pkg::ST_EXQ: exq_ff <= rx_ff[CW-1] ? offx_ff - step : offx_ff + step;
         rsrf_pkg::ST_EXCHK: begin
            if (exq_ff != '0) begin
               any_ff <= 1'b1;
            end
            rem_ff      <= '0;
            dvs_ff      <= 31'(cs_abs[14:0]);
            num_ff      <= {exq_abs[21:0], 14'b0};
            q_ff        <= '0;
            cnt_ff      <= 6'(rsrf_pkg::DIV_R_STEPS);
            div_kind_ff <= 1'b1;
         end
         rsrf_pkg::ST_CMP: if (comp < QW'(best_ff)) best_ff <= 20'(comp);
         rsrf_pkg::ST_WINC: wi_ff <= wi_ff + CNT_W'(1);
         rsrf_pkg::ST_FIN: begin
            res_dist_ff <= best_ff[18:8];
            res_hit_ff  <= any_ff;
         end
         rsrf_pkg::ST_DONE: begin
            // hold a waiting response until it is taken
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_ff <= {4'b0, 7'(wall_total_ff), res_status_ff, res_hit_ff, res_dist_ff};
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      wall_total_ff <= CNT_W'(rsrf_pkg::MAX_OBST))
      else $error("wall count above table size");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rsrf_pkg::ST_DONE)
      else $error("response raised outside done state");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == rsrf_pkg::ST_DIV |-> dvs_ff != '0)
      else $error("divider started with zero divisor");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsrf_pkg::ST_EXEC && cmd_ff == rsrf_pkg::CMD_APPEND && full)
      |=> full && res_status_ff)
      else $error("append on full table changed count or lost status");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == rsrf_pkg::ST_WPREP |-> wi_ff < wall_total_ff)
      else $error("wall scan beyond stored walls");
`endif

endmodule
